/* hw/rtl/sfrc_pkg.sv */
`default_nettype none
package sfrc_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_START_BYTE    = 3'd0;
	localparam logic [2:0] REG_END_BYTE      = 3'd1;
	localparam logic [2:0] REG_OWN_ADDRESS   = 3'd2;
	localparam logic [2:0] REG_CHECK_ADDRESS = 3'd3;
	localparam logic [2:0] REG_HUNT_LIMIT    = 3'd4;
	localparam logic [2:0] REG_WIDE_LENGTH   = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_NO_END  = 3'd5;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ADDR,
		PH_LENHI,
		PH_LENLO,
		PH_DATA,
		PH_BCC,
		PH_SUM,
		PH_END
	} phase_t;

	typedef enum logic [2:0] {
		OP_TAKE,
		OP_DATA,
		OP_RX_BCC,
		OP_RX_SUM,
		OP_END_OK,
		OP_TIMEOUT,
		OP_NO_END
	} op_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       timed_out;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [7:0]  frame_address;
		logic [15:0] frame_length;
		logic [2:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] own_address;
		logic       check_address;
		logic [3:0] hunt_limit;
		logic       wide_length;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [15:0] idx;
		logic [7:0]  addr;
		logic [15:0] len;
	} cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/sfrc_front.sv */
`default_nettype none
module sfrc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfrc_pkg::cfg_t    cfg,
	input  wire logic              accept,
	input  wire sfrc_pkg::in_item_t item,
	output logic                   push,
	output sfrc_pkg::cmd_t         cmd
);

	sfrc_pkg::phase_t phase_q, phase_d;
	logic [3:0]  hunt_count_q, hunt_count_d;
	logic [7:0]  addr_q, addr_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [15:0] count_inc;
	logic        hunt_expired;
	logic        addr_bad;
	logic [7:0]  b;

	assign b            = item.rx_byte;
	assign count_inc    = count_q + 16'd1;
	assign hunt_expired = !cfg.wide_length && (hunt_count_q >= cfg.hunt_limit);
	assign addr_bad     = (cfg.wide_length || cfg.check_address) && (b != cfg.own_address);

	// Next state and frame holds.
	always_comb begin
		phase_d      = phase_q;
		hunt_count_d = hunt_count_q;
		addr_d       = addr_q;
		len_d        = len_q;
		count_d      = count_q;
		if (accept) begin
			if (item.timed_out) begin
				phase_d      = sfrc_pkg::PH_HUNT;
				hunt_count_d = '0;
				addr_d       = '0;
				len_d        = '0;
				count_d      = '0;
			end else begin
				case (phase_q)
					sfrc_pkg::PH_HUNT: begin
						if (hunt_expired) begin
							hunt_count_d = '0;
						end else begin
							if (!cfg.wide_length && hunt_count_q != 4'hF)
								hunt_count_d = hunt_count_q + 4'd1;
							if (b == cfg.start_byte)
								phase_d = sfrc_pkg::PH_ADDR;
						end
						addr_d  = '0;
						len_d   = '0;
						count_d = '0;
					end
					sfrc_pkg::PH_ADDR: begin
						if (addr_bad) begin
							phase_d      = sfrc_pkg::PH_HUNT;
							hunt_count_d = '0;
							addr_d       = '0;
							len_d        = '0;
						end else begin
							addr_d  = b;
							phase_d = cfg.wide_length ? sfrc_pkg::PH_LENHI : sfrc_pkg::PH_LENLO;
						end
					end
					sfrc_pkg::PH_LENHI: begin
						len_d   = {b, 8'h00};
						phase_d = sfrc_pkg::PH_LENLO;
					end
					sfrc_pkg::PH_LENLO: begin
						len_d   = len_q | {8'h00, b};
						count_d = '0;
						phase_d = ((len_q | {8'h00, b}) == 16'd0) ? sfrc_pkg::PH_BCC
							: sfrc_pkg::PH_DATA;
					end
					sfrc_pkg::PH_DATA: begin
						count_d = count_inc;
						if (count_inc >= len_q)
							phase_d = sfrc_pkg::PH_BCC;
					end
					sfrc_pkg::PH_BCC: phase_d = sfrc_pkg::PH_SUM;
					sfrc_pkg::PH_SUM: phase_d = sfrc_pkg::PH_END;
					sfrc_pkg::PH_END: begin
						// A wrong end byte keeps the hunt count running.
						if (b == cfg.end_byte)
							hunt_count_d = '0;
						phase_d = sfrc_pkg::PH_HUNT;
						addr_d  = '0;
						len_d   = '0;
						count_d = '0;
					end
					default: begin
						phase_d      = sfrc_pkg::PH_HUNT;
						hunt_count_d = '0;
						addr_d       = '0;
						len_d        = '0;
						count_d      = '0;
					end
				endcase
			end
		end
	end

	// Command sent to the back end for the transaction.
	always_comb begin
		push     = 1'b0;
		cmd.op   = sfrc_pkg::OP_TAKE;
		cmd.data = b;
		cmd.idx  = count_q;
		cmd.addr = addr_q;
		cmd.len  = len_q;
		if (accept) begin
			if (item.timed_out) begin
				push   = 1'b1;
				cmd.op = sfrc_pkg::OP_TIMEOUT;
			end else begin
				case (phase_q)
					sfrc_pkg::PH_HUNT: begin
						push   = hunt_expired;
						cmd.op = sfrc_pkg::OP_TIMEOUT;
					end
					sfrc_pkg::PH_ADDR: begin
						push   = 1'b1;
						cmd.op = addr_bad ? sfrc_pkg::OP_TIMEOUT : sfrc_pkg::OP_TAKE;
					end
					sfrc_pkg::PH_LENHI, sfrc_pkg::PH_LENLO: begin
						push   = 1'b1;
						cmd.op = sfrc_pkg::OP_TAKE;
					end
					sfrc_pkg::PH_DATA: begin
						push   = 1'b1;
						cmd.op = sfrc_pkg::OP_DATA;
					end
					sfrc_pkg::PH_BCC: begin
						push   = 1'b1;
						cmd.op = sfrc_pkg::OP_RX_BCC;
					end
					sfrc_pkg::PH_SUM: begin
						push   = 1'b1;
						cmd.op = sfrc_pkg::OP_RX_SUM;
					end
					sfrc_pkg::PH_END: begin
						push   = 1'b1;
						cmd.op = (b == cfg.end_byte) ? sfrc_pkg::OP_END_OK
							: sfrc_pkg::OP_NO_END;
					end
					default: begin
						push   = 1'b0;
						cmd.op = sfrc_pkg::OP_TAKE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sfrc_pkg::PH_HUNT;
			hunt_count_q <= '0;
			addr_q       <= '0;
			len_q        <= '0;
			count_q      <= '0;
		end else begin
			phase_q      <= phase_d;
			hunt_count_q <= hunt_count_d;
			addr_q       <= addr_d;
			len_q        <= len_d;
			count_q      <= count_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/sfrc_queue.sv */
`default_nettype none
module sfrc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sfrc_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output logic                full,
	output logic                head_valid,
	output sfrc_pkg::cmd_t      head
);

	sfrc_pkg::cmd_t                entry_q [sfrc_pkg::QDEPTH];
	logic [sfrc_pkg::QAW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [sfrc_pkg::QCW-1:0]      count_q;

	assign full       = (count_q == sfrc_pkg::QCW'(sfrc_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sfrc_pkg::QCW'(sfrc_pkg::QDEPTH))
		else $error("command queue count beyond depth");

endmodule
`default_nettype wire

/* hw/rtl/sfrc_back.sv */
`default_nettype none
module sfrc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire sfrc_pkg::cmd_t  head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output sfrc_pkg::out_item_t  out_data
);

	logic [7:0] xor_acc_q, sum_acc_q, rx_xor_q, rx_sum_q;
	logic       out_valid_q;
	sfrc_pkg::out_item_t out_q, result;
	logic       emits;

	assign emits = (head.op == sfrc_pkg::OP_DATA) || (head.op == sfrc_pkg::OP_END_OK)
		|| (head.op == sfrc_pkg::OP_TIMEOUT) || (head.op == sfrc_pkg::OP_NO_END);

	// Silent commands never wait on the output register.
	assign pop = head_valid && (!emits || !out_valid_q || !out_stall);

	always_comb begin
		result.kind          = sfrc_pkg::KIND_STATUS;
		result.data_byte     = '0;
		result.byte_index    = '0;
		result.frame_address = head.addr;
		result.frame_length  = head.len;
		result.status        = sfrc_pkg::ST_OK;
		case (head.op)
			sfrc_pkg::OP_DATA: begin
				result.kind       = sfrc_pkg::KIND_DATA;
				result.data_byte  = head.data;
				result.byte_index = head.idx;
			end
			sfrc_pkg::OP_END_OK:
				result.status = {1'b0, rx_sum_q != sum_acc_q, rx_xor_q != xor_acc_q};
			sfrc_pkg::OP_TIMEOUT: result.status = sfrc_pkg::ST_TIMEOUT;
			sfrc_pkg::OP_NO_END:  result.status = sfrc_pkg::ST_NO_END;
			default:              result.status = sfrc_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_acc_q <= '0;
			sum_acc_q <= '0;
			rx_xor_q  <= '0;
			rx_sum_q  <= '0;
		end else if (pop) begin
			case (head.op)
				sfrc_pkg::OP_TAKE, sfrc_pkg::OP_DATA: begin
					xor_acc_q <= xor_acc_q ^ head.data;
					sum_acc_q <= sum_acc_q + head.data;
				end
				sfrc_pkg::OP_RX_BCC: rx_xor_q <= head.data;
				sfrc_pkg::OP_RX_SUM: rx_sum_q <= head.data;
				default: begin
					// Every status closes the frame, so the checks start afresh.
					xor_acc_q <= '0;
					sum_acc_q <= '0;
					rx_xor_q  <= '0;
					rx_sum_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && emits)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop && emits)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emits && head.op != sfrc_pkg::OP_DATA) |=>
		(xor_acc_q == 8'h00 && sum_acc_q == 8'h00))
		else $error("check sums not cleared after a frame status");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(pop && emits))
		else $error("held result overwritten");

	a_data_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.op == sfrc_pkg::OP_DATA) |=>
		(out_valid_q && out_q.kind == sfrc_pkg::KIND_DATA && out_q.status == sfrc_pkg::ST_OK))
		else $error("payload command did not yield a payload result");

endmodule
`default_nettype wire

/* hw/rtl/serial_frame_receive_check_core.sv */
`default_nettype none
// Frame receiver: one received byte or timeout mark per input transaction, at up to one
// transaction per clock. The front state machine decides each byte combinationally and
// hands a command to a four-entry queue; the back end keeps the XOR and SUM checks and
// loads the output register. A result is held in the queue and then the output register;
// the input stalls only when four commands wait behind a stalled output. Payload bytes
// come out as they arrive; on status 5 the consumer drops the payload already delivered.
module serial_frame_receive_check_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sfrc_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sfrc_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [7:0]          cfg_wdata
);

	sfrc_pkg::cfg_t cfg_q;
	sfrc_pkg::cmd_t cmd, head;
	logic push, pop, full, head_valid, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= 8'd2;
			cfg_q.end_byte      <= 8'd3;
			cfg_q.own_address   <= 8'd0;
			cfg_q.check_address <= 1'b1;
			cfg_q.hunt_limit    <= 4'd11;
			cfg_q.wide_length   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfrc_pkg::REG_START_BYTE:    cfg_q.start_byte    <= cfg_wdata;
				sfrc_pkg::REG_END_BYTE:      cfg_q.end_byte      <= cfg_wdata;
				sfrc_pkg::REG_OWN_ADDRESS:   cfg_q.own_address   <= cfg_wdata;
				sfrc_pkg::REG_CHECK_ADDRESS: cfg_q.check_address <= cfg_wdata[0];
				sfrc_pkg::REG_HUNT_LIMIT:    cfg_q.hunt_limit    <= cfg_wdata[3:0];
				sfrc_pkg::REG_WIDE_LENGTH:   cfg_q.wide_length   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	sfrc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.item   (in_data),
		.push   (push),
		.cmd    (cmd)
	);

	sfrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	sfrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

/* tb/sfrc_result_checker.sv */
`default_nettype none
// Watches the input, output and register ports, works out the frame results that each
// accepted input transaction should cause and compares every accepted output transaction
// with the oldest one still due.
module sfrc_result_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire sfrc_pkg::in_item_t  in_data,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire sfrc_pkg::out_item_t out_data,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [7:0]          cfg_wdata,
	output int                       fail_count,
	output int                       pending
);
	import sfrc_pkg::*;

	localparam logic [2:0] ST_BCC_ERR = 3'd1;
	localparam logic [2:0] ST_SUM_ERR = 3'd2;

	cfg_t       regs;
	phase_t     phase;
	logic [3:0] hunt_cnt;
	logic [7:0] addr_q;
	logic [15:0] len_q;
	logic [15:0] pay_cnt;
	logic [7:0] xor_run;
	logic [7:0] sum_run;
	logic [7:0] got_xor;
	logic [7:0] got_sum;

	out_item_t  due_results[$];
	int         n_bad;

	function automatic out_item_t status_of(input logic [2:0] st);
		out_item_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.frame_address = addr_q;
		r.frame_length = len_q;
		r.status = st;
		return r;
	endfunction

	task automatic clear_frame();
		phase = PH_HUNT;
		addr_q = '0;
		len_q = '0;
		pay_cnt = '0;
		xor_run = '0;
		sum_run = '0;
		got_xor = '0;
		got_sum = '0;
	endtask

	task automatic go_idle();
		clear_frame();
		hunt_cnt = '0;
	endtask

	task automatic absorb(input logic [7:0] b);
		xor_run = xor_run ^ b;
		sum_run = sum_run + b;
	endtask

	task automatic frame_step(input in_item_t it, output bit has, output out_item_t res);
		logic [7:0] b;
		b = it.rx_byte;
		has = 1'b0;
		res = '0;
		if (it.timed_out) begin
			res = status_of(ST_TIMEOUT);
			has = 1'b1;
			go_idle();
		end else begin
			case (phase)
				PH_ADDR: begin
					if ((regs.wide_length || regs.check_address) && b != regs.own_address) begin
						res = status_of(ST_TIMEOUT);
						has = 1'b1;
						go_idle();
					end else begin
						addr_q = b;
						absorb(b);
						if (regs.wide_length)
							phase = PH_LENHI;
						else
							phase = PH_LENLO;
					end
				end
				PH_LENHI: begin
					len_q = {b, 8'h00};
					absorb(b);
					phase = PH_LENLO;
				end
				PH_LENLO: begin
					len_q = len_q | {8'h00, b};
					absorb(b);
					pay_cnt = '0;
					if (len_q == 16'd0)
						phase = PH_BCC;
					else
						phase = PH_DATA;
				end
				PH_DATA: begin
					res.kind = KIND_DATA;
					res.data_byte = b;
					res.byte_index = pay_cnt;
					res.frame_address = addr_q;
					res.frame_length = len_q;
					res.status = ST_OK;
					has = 1'b1;
					absorb(b);
					pay_cnt = pay_cnt + 16'd1;
					if (pay_cnt >= len_q)
						phase = PH_BCC;
				end
				PH_BCC: begin
					got_xor = b;
					phase = PH_SUM;
				end
				PH_SUM: begin
					got_sum = b;
					phase = PH_END;
				end
				PH_END: begin
					has = 1'b1;
					if (b == regs.end_byte) begin
						res = status_of((got_xor != xor_run ? ST_BCC_ERR : ST_OK) |
							(got_sum != sum_run ? ST_SUM_ERR : ST_OK));
						go_idle();
					end else begin
						// The hunt count survives a frame dropped for a bad end byte.
						res = status_of(ST_NO_END);
						clear_frame();
					end
				end
				default: begin
					if (!regs.wide_length && hunt_cnt >= regs.hunt_limit) begin
						res = status_of(ST_TIMEOUT);
						has = 1'b1;
						go_idle();
					end else begin
						if (!regs.wide_length && hunt_cnt != 4'hF)
							hunt_cnt = hunt_cnt + 4'd1;
						if (b == regs.start_byte) begin
							clear_frame();
							phase = PH_ADDR;
						end
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit        has;
		out_item_t res;
		out_item_t want;
		if (!arst_n) begin
			regs = '{start_byte: 8'h02, end_byte: 8'h03, own_address: 8'h00,
				check_address: 1'b1, hunt_limit: 4'd11, wide_length: 1'b0};
			go_idle();
			due_results.delete();
			n_bad = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_BYTE:    regs.start_byte = cfg_wdata;
					REG_END_BYTE:      regs.end_byte = cfg_wdata;
					REG_OWN_ADDRESS:   regs.own_address = cfg_wdata;
					REG_CHECK_ADDRESS: regs.check_address = cfg_wdata[0];
					REG_HUNT_LIMIT:    regs.hunt_limit = cfg_wdata[3:0];
					REG_WIDE_LENGTH:   regs.wide_length = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				frame_step(in_data, has, res);
				if (has)
					due_results.push_back(res);
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) begin
						$write("unexpected result transaction: kind %0d data %h index %0d ",
							out_data.kind, out_data.data_byte, out_data.byte_index);
						$display("addr %h len %0d status %0d",
							out_data.frame_address, out_data.frame_length,
							out_data.status);
					end
				end else begin
					want = due_results.pop_front();
					if (out_data.kind != want.kind || out_data.data_byte != want.data_byte ||
							out_data.byte_index != want.byte_index ||
							out_data.frame_address != want.frame_address ||
							out_data.frame_length != want.frame_length ||
							out_data.status != want.status) begin
						n_bad++;
						if (n_bad <= 10) begin
							$write("result mismatch: expected kind %0d data %h index %0d ",
								want.kind, want.data_byte, want.byte_index);
							$display("addr %h len %0d status %0d",
								want.frame_address, want.frame_length, want.status);
							$write("                 got      kind %0d data %h index %0d ",
								out_data.kind, out_data.data_byte, out_data.byte_index);
							$display("addr %h len %0d status %0d",
								out_data.frame_address, out_data.frame_length,
								out_data.status);
						end
					end
				end
			end
			fail_count <= n_bad;
			pending <= due_results.size();
		end
	end

endmodule
`default_nettype wire

/* tb/tb_serial_frame_receive_check_core.sv */
`default_nettype none
module tb_serial_frame_receive_check_core;
	import sfrc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_wdata;

	int          fail_count;
	int          pending;
	bit          calm;
	int unsigned n_sent;
	cfg_t        cfg_now;

	always #1 clk = ~clk;

	serial_frame_receive_check_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	sfrc_result_checker results_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 20);
	end

	initial begin
		#400000;
		$display("tb_serial_frame_receive_check_core: FAIL");
		$finish;
	end

	// One byte or timeout mark; returns at the edge where the transaction is accepted.
	task automatic send_item(input logic [7:0] b, input logic to);
		if (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{rx_byte: b, timed_out: to};
		do
			@(posedge clk);
		while (in_stall);
		n_sent++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic configure(input cfg_t c);
		write_reg(REG_START_BYTE, c.start_byte);
		write_reg(REG_END_BYTE, c.end_byte);
		write_reg(REG_OWN_ADDRESS, c.own_address);
		write_reg(REG_CHECK_ADDRESS, {7'd0, c.check_address});
		write_reg(REG_HUNT_LIMIT, {4'd0, c.hunt_limit});
		write_reg(REG_WIDE_LENGTH, {7'd0, c.wide_length});
		cfg_we <= 1'b0;
		cfg_now = c;
	endtask

	// Holds the sender back until every result due has come out, then lets the
	// pipeline empty of work that causes no result.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_frame(input bit addr_ok, input int unsigned len, input bit bcc_bad,
			input bit sum_bad, input bit end_bad, input bit cut_short);
		logic [7:0]  body[$];
		logic [7:0]  fx;
		logic [7:0]  fs;
		int unsigned npay;
		int unsigned hdr;
		int unsigned stop;
		int unsigned k;
		body.push_back(addr_ok ? cfg_now.own_address : 8'($urandom));
		if (cfg_now.wide_length)
			body.push_back(8'(len >> 8));
		body.push_back(8'(len));
		hdr = body.size();
		npay = (cut_short && len > 8) ? 8 : len;
		for (k = 0; k < npay; k++)
			body.push_back(8'($urandom));
		fx = '0;
		fs = '0;
		foreach (body[i]) begin
			fx = fx ^ body[i];
			fs = fs + body[i];
		end
		if (bcc_bad)
			fx = fx ^ 8'($urandom_range(1, 255));
		if (sum_bad)
			fs = fs ^ 8'($urandom_range(1, 255));
		body.push_back(fx);
		body.push_back(fs);
		body.push_back(end_bad ? cfg_now.end_byte ^ 8'($urandom_range(1, 255))
			: cfg_now.end_byte);
		if (!cut_short)
			stop = body.size();
		else if (npay == len)
			stop = $urandom_range(body.size() - 1);
		else
			stop = $urandom_range(hdr + npay);
		send_item(cfg_now.start_byte, 1'b0);
		for (k = 0; k < stop; k++)
			send_item(body[k], 1'b0);
		if (cut_short)
			send_item(8'($urandom), 1'b1);
	endtask

	task automatic run_traffic(input int unsigned quota);
		int unsigned first;
		int unsigned r;
		int unsigned k;
		int unsigned len;
		first = n_sent;
		while (n_sent - first < quota) begin
			r = $urandom_range(99);
			k = $urandom_range(99);
			len = (k < 10) ? 0 : (k < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			if (r < 60) begin
				send_frame($urandom_range(9) != 0, len, $urandom_range(4) == 0,
					$urandom_range(4) == 0, $urandom_range(9) == 0, 1'b0);
			end else if (r < 72) begin
				// Broken frame; in wide mode the length may be far beyond what is sent.
				if (cfg_now.wide_length && $urandom_range(1) == 1)
					len = $urandom_range(65535);
				send_frame(1'b1, len, 1'b0, 1'b0, 1'b0, 1'b1);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 5))
					send_item(($urandom_range(3) == 0) ? cfg_now.start_byte
						: 8'($urandom), 1'b0);
			end else begin
				send_item(8'($urandom), 1'b1);
			end
		end
	endtask

	initial begin
		cfg_t c;
		int   p;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_START_BYTE;
		cfg_wdata <= '0;
		calm <= 1'b0;
		n_sent = 0;
		cfg_now = '{start_byte: 8'h02, end_byte: 8'h03, own_address: 8'h00,
			check_address: 1'b1, hunt_limit: 4'd11, wide_length: 1'b0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Good frame carrying both payload extremes.
		send_item(8'h02, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h02, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFD, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h03, 1'b0);
		// Empty payload with both check bytes wrong.
		send_item(8'h02, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h11, 1'b0);
		send_item(8'h22, 1'b0);
		send_item(8'h03, 1'b0);
		// Address that is not ours.
		send_item(8'h02, 1'b0);
		send_item(8'h05, 1'b0);
		// Lone timeout mark.
		send_item(8'hFF, 1'b1);
		// Frame closed by the wrong end byte.
		send_item(8'h02, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'hAB, 1'b0);
		send_item(8'hAB, 1'b0);
		send_item(8'h77, 1'b0);
		settle();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: c = '{start_byte: 8'h00, end_byte: 8'hFF, own_address: 8'hFF,
					check_address: 1'b0, hunt_limit: 4'd15, wide_length: 1'b0};
				1: c = '{start_byte: 8'hFF, end_byte: 8'h00, own_address: 8'h5A,
					check_address: 1'b1, hunt_limit: 4'd1, wide_length: 1'b1};
				2: c = '{start_byte: 8'($urandom), end_byte: 8'($urandom),
					own_address: 8'($urandom), check_address: 1'b1, hunt_limit: 4'd1,
					wide_length: 1'b0};
				3: c = '{start_byte: 8'($urandom), end_byte: 8'($urandom),
					own_address: 8'($urandom), check_address: 1'b0,
					hunt_limit: 4'($urandom_range(1, 15)), wide_length: 1'b1};
				4: c = '{start_byte: 8'($urandom), end_byte: 8'($urandom),
					own_address: 8'($urandom), check_address: 1'($urandom_range(1)),
					hunt_limit: 4'($urandom_range(1, 15)), wide_length: 1'b0};
				default: c = '{start_byte: 8'h02, end_byte: 8'h03, own_address: 8'h00,
					check_address: 1'b1, hunt_limit: 4'd11, wide_length: 1'b0};
			endcase
			configure(c);
			calm <= (p == 2);
			run_traffic(70);
			settle();
		end

		if (fail_count == 0 && pending == 0)
			$display("tb_serial_frame_receive_check_core: PASS");
		else
			$display("tb_serial_frame_receive_check_core: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/sfrc_pkg.sv
hw/rtl/sfrc_front.sv
hw/rtl/sfrc_queue.sv
hw/rtl/sfrc_back.sv
hw/rtl/serial_frame_receive_check_core.sv
tb/sfrc_result_checker.sv
tb/tb_serial_frame_receive_check_core.sv
